### rtl/avt_pkg.sv
package avt_pkg;

  // Fixed field widths of the vector and matrix data.
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned PROD_W      = 2 * DATA_W;
  localparam int unsigned SUM_W       = PROD_W + 2;
  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned SEL_W       = 2;
  localparam int unsigned DIM         = 4;
  localparam int unsigned VEC_N       = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef logic signed [DATA_W-1:0] q_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Operation codes carried on the func field.
  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD_FWD  = 3'd0,
    FN_LOAD_INV  = 3'd1,
    FN_POINT_FWD = 3'd2,
    FN_POINT_INV = 3'd3,
    FN_DIR_FWD   = 3'd4,
    FN_DIR_INV   = 3'd5,
    FN_NORMAL    = 3'd6
  } func_t;

  // One transform job: the vector, the three coefficient sets picked at
  // accept time (coef[i][k] multiplies vec[k] for output i) and the
  // translation term of each output.
  typedef struct packed {
    q_t [VEC_N-1:0]            vec;
    q_t [VEC_N-1:0][VEC_N-1:0] coef;
    q_t [VEC_N-1:0]            trans;
  } job_t;

  // Handshake group between the queue and one of its neighbors.
  typedef struct packed {
    logic valid;
  } qlink_t;

endpackage

### rtl/avt_front.sv
module avt_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                q_full,
  input  logic [avt_pkg::FUNC_W-1:0]          in_func,
  input  logic [avt_pkg::SEL_W-1:0]           in_row_sel,
  input  logic [avt_pkg::SEL_W-1:0]           in_col_sel,
  input  logic signed [avt_pkg::DATA_W-1:0]   in_coef,
  input  logic signed [avt_pkg::DATA_W-1:0]   in_x_in,
  input  logic signed [avt_pkg::DATA_W-1:0]   in_y_in,
  input  logic signed [avt_pkg::DATA_W-1:0]   in_z_in,
  output logic                                in_stall,
  output avt_pkg::qlink_t                     push,
  output avt_pkg::job_t                       push_job
);
  import avt_pkg::*;

  localparam q_t ONE = q_t'(64'(1) << FRAC_BITS);

  q_t    fwd_r [DIM][DIM];
  q_t    inv_r [DIM][DIM];
  logic  accept;
  logic  is_xform;
  logic  use_inv;
  logic  use_trans;
  func_t fn;

  assign fn       = func_t'(in_func);
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Classify the beat.
  always_comb begin
    is_xform  = 1'b0;
    use_inv   = 1'b0;
    use_trans = 1'b0;
    unique case (fn) inside
      FN_POINT_FWD: begin
        is_xform  = 1'b1;
        use_trans = 1'b1;
      end
      FN_POINT_INV: begin
        is_xform  = 1'b1;
        use_inv   = 1'b1;
        use_trans = 1'b1;
      end
      FN_DIR_FWD: begin
        is_xform = 1'b1;
      end
      FN_DIR_INV, FN_NORMAL: begin
        is_xform = 1'b1;
        use_inv  = 1'b1;
      end
      default: begin
        is_xform = 1'b0;
      end
    endcase
  end

  // Matrix registers, reset to identity and written one entry per load beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          fwd_r[r][c] <= (r == c) ? ONE : '0;
          inv_r[r][c] <= (r == c) ? ONE : '0;
        end
      end
    end else if (accept) begin
      if (fn == FN_LOAD_FWD) begin
        fwd_r[in_row_sel][in_col_sel] <= in_coef;
      end
      if (fn == FN_LOAD_INV) begin
        inv_r[in_row_sel][in_col_sel] <= in_coef;
      end
    end
  end

  // Pick the coefficients now so later loads cannot disturb a queued job.
  always_comb begin
    push_job.vec[0] = in_x_in;
    push_job.vec[1] = in_y_in;
    push_job.vec[2] = in_z_in;
    for (int i = 0; i < VEC_N; i++) begin
      for (int k = 0; k < VEC_N; k++) begin
        if (fn == FN_NORMAL) begin
          push_job.coef[i][k] = inv_r[i][k];
        end else if (use_inv) begin
          push_job.coef[i][k] = inv_r[k][i];
        end else begin
          push_job.coef[i][k] = fwd_r[k][i];
        end
      end
      if (!use_trans) begin
        push_job.trans[i] = '0;
      end else if (use_inv) begin
        push_job.trans[i] = inv_r[DIM-1][i];
      end else begin
        push_job.trans[i] = fwd_r[DIM-1][i];
      end
    end
  end

  assign push.valid = accept && is_xform;

endmodule

### rtl/avt_queue.sv
module avt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  avt_pkg::qlink_t push,
  input  avt_pkg::job_t   push_job,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output avt_pkg::job_t   head_job
);
  import avt_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;

  // Occupancy follows the push and pop of each cycle.
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### rtl/avt_back.sv
module avt_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               head_valid,
  input  avt_pkg::job_t                      head_job,
  input  logic                               out_stall,
  output logic                               pop,
  output logic                               out_valid,
  output logic signed [avt_pkg::DATA_W-1:0]  out_x_out,
  output logic signed [avt_pkg::DATA_W-1:0]  out_y_out,
  output logic signed [avt_pkg::DATA_W-1:0]  out_z_out
);
  import avt_pkg::*;

  localparam sum_t SAT_HI = sum_t'(64'sd2147483647);
  localparam sum_t SAT_LO = -SAT_HI - sum_t'(1);

  logic  advance;
  logic  s1_valid_r;
  prod_t s1_prod_r [VEC_N][VEC_N];
  q_t    s1_trans_r [VEC_N];
  logic  s2_valid_r;
  sum_t  s2_sum_r [VEC_N];
  logic  out_valid_r;
  q_t    out_r [VEC_N];
  q_t    sat [VEC_N];
  sum_t  shifted [VEC_N];

  // The whole pipe moves unless a finished beat waits at the output.
  assign advance = !(out_valid_r && out_stall);
  assign pop     = advance && head_valid;

  // Control of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= head_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // Stage one: nine full products.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < VEC_N; i++) begin
        for (int k = 0; k < VEC_N; k++) begin
          s1_prod_r[i][k] <= prod_t'(head_job.vec[k]) * prod_t'(head_job.coef[i][k]);
        end
        s1_trans_r[i] <= head_job.trans[i];
      end
    end
  end

  // Stage two: exact sum with the translation aligned to the fraction point.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < VEC_N; i++) begin
        s2_sum_r[i] <= sum_t'(s1_prod_r[i][0]) + sum_t'(s1_prod_r[i][1])
                     + sum_t'(s1_prod_r[i][2]) + (sum_t'(s1_trans_r[i]) <<< FRAC_BITS);
      end
    end
  end

  // Floor shift and saturation into the output register.
  always_comb begin
    for (int i = 0; i < VEC_N; i++) begin
      shifted[i] = s2_sum_r[i] >>> FRAC_BITS;
      if (shifted[i] > SAT_HI) begin
        sat[i] = q_t'(SAT_HI);
      end else if (shifted[i] < SAT_LO) begin
        sat[i] = q_t'(SAT_LO);
      end else begin
        sat[i] = q_t'(shifted[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < VEC_N; i++) begin
        out_r[i] <= sat[i];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_x_out = out_r[0];
  assign out_y_out = out_r[1];
  assign out_z_out = out_r[2];

endmodule

### rtl/affine_vector_transform.sv
// Affine 4x4 vector transform. Load beats (func 0 and 1) write one Q16.16
// entry of the forward or inverse matrix and give no result; transform beats
// (func 2 to 6) send x, y, z through a matrix as a point, a direction or a
// normal and give one saturated result beat. Unused func 7 is dropped. One
// beat is taken per clock while in_stall is low; a transform job goes through
// the job queue, stage one, stage two and the output register. The front
// picks the matrix coefficients at accept time, so a load takes effect for
// every later beat. A two-entry job queue sits in front of a three-stage back
// end (nine parallel 32x32 multipliers, one exact four-term sum per output,
// then shift and saturate), and in_stall rises only when that queue is full.
module affine_vector_transform #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [avt_pkg::FUNC_W-1:0]         in_func,
  input  logic [avt_pkg::SEL_W-1:0]          in_row_sel,
  input  logic [avt_pkg::SEL_W-1:0]          in_col_sel,
  input  logic signed [avt_pkg::DATA_W-1:0]  in_coef,
  input  logic signed [avt_pkg::DATA_W-1:0]  in_x_in,
  input  logic signed [avt_pkg::DATA_W-1:0]  in_y_in,
  input  logic signed [avt_pkg::DATA_W-1:0]  in_z_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [avt_pkg::DATA_W-1:0]  out_x_out,
  output logic signed [avt_pkg::DATA_W-1:0]  out_y_out,
  output logic signed [avt_pkg::DATA_W-1:0]  out_z_out
);
  import avt_pkg::*;

  qlink_t push;
  job_t   push_job;
  logic   q_full;
  logic   head_valid;
  job_t   head_job;
  logic   pop;

  avt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .q_full     (q_full),
    .in_func    (in_func),
    .in_row_sel (in_row_sel),
    .in_col_sel (in_col_sel),
    .in_coef    (in_coef),
    .in_x_in    (in_x_in),
    .in_y_in    (in_y_in),
    .in_z_in    (in_z_in),
    .in_stall   (in_stall),
    .push       (push),
    .push_job   (push_job)
  );

  avt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  avt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .out_stall  (out_stall),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_x_out  (out_x_out),
    .out_y_out  (out_y_out),
    .out_z_out  (out_z_out)
  );

endmodule

### rtl/avt_checker.sv
module avt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_x_out,
  input logic [31:0] out_y_out,
  input logic [31:0] out_z_out
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_x_out) && $stable(out_y_out)
                               && $stable(out_z_out))
    else $error("result payload changed while stalled");

  // With the output free, the back end drains and the queue cannot stay full.
  a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |=> !in_stall)
    else $error("input stalled although the output was taken");

  // Leaving reset, the pipe is empty and open.
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid && !in_stall)
    else $error("pipe not empty after reset");

endmodule

bind affine_vector_transform avt_checker u_avt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_x_out (out_x_out),
  .out_y_out (out_y_out),
  .out_z_out (out_z_out)
);

### bench/affine_vector_transform_tb.sv
module affine_vector_transform_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import avt_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
  localparam q_t ONE = 32'sh0001_0000;
  localparam q_t Q_MAX = 32'sh7fff_ffff;
  localparam q_t Q_MIN = 32'sh8000_0000;
  localparam int unsigned RANDOM_PER_PHASE = 225;

  typedef logic signed [PROD_W+3:0] wide_t;

  typedef struct packed {
    q_t x;
    q_t y;
    q_t z;
  } vec3_t;

  // Tracks both matrices and the queue of vectors the block owes us.
  class affine_scoreboard;
    q_t          fwd_m[DIM][DIM];
    q_t          inv_m[DIM][DIM];
    vec3_t       expected_vectors[$];
    int unsigned mismatch_count;

    function new();
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          fwd_m[r][c] = (r == c) ? ONE : '0;
          inv_m[r][c] = (r == c) ? ONE : '0;
        end
      end
      mismatch_count = 0;
    endfunction

    // Exact three-term dot product plus aligned translation, floored and saturated.
    static function q_t dot_floor_sat(q_t a0, q_t a1, q_t a2, q_t b0, q_t b1, q_t b2,
                                      q_t t);
      wide_t acc;
      acc = wide_t'(a0) * wide_t'(b0) + wide_t'(a1) * wide_t'(b1) +
            wide_t'(a2) * wide_t'(b2) + (wide_t'(t) <<< FRAC);
      acc = acc >>> FRAC;
      if (acc > 68'sd2147483647) return Q_MAX;
      if (acc < -68'sd2147483648) return Q_MIN;
      return q_t'(acc);
    endfunction

    // Apply one accepted input beat: update a matrix or predict a vector.
    function void note_input(logic [FUNC_W-1:0] fn, logic [SEL_W-1:0] row,
                             logic [SEL_W-1:0] col, q_t coef, q_t x, q_t y, q_t z);
      q_t m[DIM][DIM];
      q_t res[VEC_N];
      q_t t;
      case (fn) inside
        FN_LOAD_FWD: fwd_m[row][col] = coef;
        FN_LOAD_INV: inv_m[row][col] = coef;
        FN_POINT_FWD, FN_POINT_INV, FN_DIR_FWD, FN_DIR_INV: begin
          if (fn == FN_POINT_FWD || fn == FN_DIR_FWD) m = fwd_m;
          else m = inv_m;
          for (int i = 0; i < VEC_N; i++) begin
            t = (fn == FN_POINT_FWD || fn == FN_POINT_INV) ? m[3][i] : '0;
            res[i] = dot_floor_sat(x, y, z, m[0][i], m[1][i], m[2][i], t);
          end
          expected_vectors.push_back('{res[0], res[1], res[2]});
        end
        FN_NORMAL: begin
          // Normals go through the transposed inverse.
          for (int i = 0; i < VEC_N; i++) begin
            res[i] = dot_floor_sat(x, y, z, inv_m[i][0], inv_m[i][1], inv_m[i][2], '0);
          end
          expected_vectors.push_back('{res[0], res[1], res[2]});
        end
        default: ;
      endcase
    endfunction

    // Compare one result beat with the oldest predicted vector.
    function void check_result(q_t x, q_t y, q_t z);
      vec3_t e;
      if (expected_vectors.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: got %h %h %h", x, y, z);
        return;
      end
      e = expected_vectors.pop_front();
      if (e.x !== x || e.y !== y || e.z !== z) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result mismatch: x exp %h got %h, y exp %h got %h, z exp %h got %h",
                   e.x, x, e.y, y, e.z, z);
      end
    endfunction

    function bit passed();
      return mismatch_count == 0 && expected_vectors.size() == 0;
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [FUNC_W-1:0]  in_func = '0;
  logic [SEL_W-1:0]   in_row_sel = '0;
  logic [SEL_W-1:0]   in_col_sel = '0;
  q_t                 in_coef = '0;
  q_t                 in_x_in = '0;
  q_t                 in_y_in = '0;
  q_t                 in_z_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  q_t                 out_x_out;
  q_t                 out_y_out;
  q_t                 out_z_out;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  affine_scoreboard sb = new();

  affine_vector_transform #(
    .FRAC_BITS(FRAC)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .in_row_sel(in_row_sel),
    .in_col_sel(in_col_sel),
    .in_coef   (in_coef),
    .in_x_in   (in_x_in),
    .in_y_in   (in_y_in),
    .in_z_in   (in_z_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x_out (out_x_out),
    .out_y_out (out_y_out),
    .out_z_out (out_z_out)
  );

  always #6 clk = ~clk;

  // Present one beat, idling first at the current rate, and hold it until taken.
  task automatic send_beat(logic [FUNC_W-1:0] fn, logic [SEL_W-1:0] row,
                           logic [SEL_W-1:0] col, q_t coef, q_t x, q_t y, q_t z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= fn;
    in_row_sel <= row;
    in_col_sel <= col;
    in_coef    <= coef;
    in_x_in    <= x;
    in_y_in    <= y;
    in_z_in    <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(fn, row, col, coef, x, y, z);
  endtask

  // Mostly values within +/-span, with a share of full-range words and extremes.
  function automatic q_t random_fixed(int unsigned span, int unsigned wild_pct);
    int unsigned roll;
    int          s;
    roll = $urandom_range(99);
    if (roll < wild_pct) return q_t'($urandom);
    if (roll < 2 * wild_pct) begin
      case ($urandom_range(5))
        0: return Q_MIN;
        1: return Q_MAX;
        2: return '0;
        3: return -32'sd1;
        4: return ONE;
        default: return -ONE;
      endcase
    end
    s = int'($urandom_range(2 * span)) - int'(span);
    return q_t'(s);
  endfunction

  // One random beat; ignored codes are flagged so they do not count.
  task automatic random_beat(output bit counted);
    int unsigned       pick;
    logic [FUNC_W-1:0] fn;
    pick = $urandom_range(99);
    if (pick < 25) fn = $urandom_range(1) ? FN_LOAD_INV : FN_LOAD_FWD;
    else if (pick < 28) fn = FN_UNUSED;
    else fn = FUNC_W'($urandom_range(FN_POINT_FWD, FN_NORMAL));
    send_beat(fn, SEL_W'($urandom_range(3)), SEL_W'($urandom_range(3)),
              random_fixed(1 << 18, 5),
              random_fixed(1 << 23, 10), random_fixed(1 << 23, 10),
              random_fixed(1 << 23, 10));
    counted = (fn != FN_UNUSED);
  endtask

  // Result side: check every accepted beat, then pick the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_x_out, out_y_out, out_z_out);
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    bit          counted;
    int unsigned n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity matrices after reset, with extreme vectors.
    send_beat(FN_POINT_FWD, 0, 0, '0, ONE, 32'shfffe_0000, Q_MAX);
    send_beat(FN_POINT_INV, 0, 0, '0, Q_MIN, Q_MAX, '0);
    send_beat(FN_DIR_FWD, 0, 0, '0, -32'sd1, 32'sd1, 32'sh1234_5678);
    send_beat(FN_DIR_INV, 0, 0, '0, Q_MIN, Q_MIN, Q_MAX);
    send_beat(FN_NORMAL, 0, 0, '0, Q_MAX, Q_MIN, -32'sd1);
    // The unused code must leave both matrices alone.
    send_beat(FN_UNUSED, 3, 3, '0, -32'sd1, -32'sd1, -32'sd1);
    send_beat(FN_POINT_FWD, 0, 0, '0, ONE, ONE, ONE);

    // Forward translation row and a corner entry, driving sums into saturation.
    send_beat(FN_LOAD_FWD, 3, 0, Q_MAX, '0, '0, '0);
    send_beat(FN_LOAD_FWD, 3, 1, Q_MIN, '0, '0, '0);
    send_beat(FN_LOAD_FWD, 3, 2, 32'sh0001_8000, '0, '0, '0);
    send_beat(FN_LOAD_FWD, 0, 0, Q_MIN, '0, '0, '0);
    send_beat(FN_POINT_FWD, 0, 0, '0, Q_MAX, Q_MAX, Q_MAX);
    send_beat(FN_DIR_FWD, 0, 0, '0, Q_MIN, 32'sd1, -32'sd1);
    send_beat(FN_POINT_FWD, 0, 0, '0, '0, '0, '0);

    // Inverse entries, including the unused column, then all inverse transforms.
    send_beat(FN_LOAD_INV, 0, 1, Q_MAX, '0, '0, '0);
    send_beat(FN_LOAD_INV, 2, 3, -32'sd1, '0, '0, '0);
    send_beat(FN_LOAD_INV, 3, 2, 32'sh8000_0001, '0, '0, '0);
    send_beat(FN_LOAD_INV, 1, 0, 32'sh0000_8000, '0, '0, '0);
    send_beat(FN_POINT_INV, 0, 0, '0, 32'sh0003_0000, -ONE, Q_MAX);
    send_beat(FN_DIR_INV, 0, 0, '0, 32'sh0003_0000, -ONE, Q_MAX);
    send_beat(FN_NORMAL, 0, 0, '0, 32'sh0003_0000, -ONE, Q_MAX);
    send_beat(FN_NORMAL, 0, 0, '0, Q_MAX, Q_MAX, Q_MAX);

    // Random beats under four idling patterns.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      n = 0;
      while (n < RANDOM_PER_PHASE) begin
        random_beat(counted);
        if (counted) n++;
      end
    end
    in_valid <= 1'b0;

    // Drain, then wait with the output free for any stray result.
    while (sb.expected_vectors.size() != 0) @(posedge clk);
    recv_stall_pct = 0;
    repeat (20) @(posedge clk);
    if (sb.passed()) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
